FILE: hdl/thick_line_quad_transform_aabb_unit_macros.svh
// assertion macros shared by the thick line quad transform unit
// expects signals named clock and reset in the module that uses them
`ifndef THICK_LINE_QUAD_TRANSFORM_AABB_UNIT_MACROS_SVH
`define THICK_LINE_QUAD_TRANSFORM_AABB_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define TLQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define TLQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/tlq_pkg.sv
// shared types, constants and helpers of the thick line quad transform unit
// no dependencies
`default_nettype none

package tlq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CW        = 32;
   localparam int LW        = 31;
   localparam int QW        = FRAC_BITS + 2;
   localparam int SAT_W     = 66 - FRAC_BITS;

   localparam logic [2:0] REG_START_X    = 3'd0;
   localparam logic [2:0] REG_START_Y    = 3'd1;
   localparam logic [2:0] REG_END_X      = 3'd2;
   localparam logic [2:0] REG_END_Y      = 3'd3;
   localparam logic [2:0] REG_LINE_WIDTH = 3'd4;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [LW-1:0]        width_type;

   typedef struct packed {
      logic [3:0][CW-1:0] x;
      logic [3:0][CW-1:0] y;
   } quad_type;

   typedef enum logic [2:0] {
      GEO_START,
      GEO_NORM,
      GEO_SQUARE,
      GEO_ROOT,
      GEO_PREP,
      GEO_DIVIDE,
      GEO_SCALE,
      GEO_CORNER
   } geo_state_type;

   // clamp a wide signed value to the coordinate range
   function automatic coord_type sat_coord(input logic signed [SAT_W-1:0] v);
      coord_type r;
      if (v[SAT_W-1:CW-1] == '0 || v[SAT_W-1:CW-1] == '1) begin
         r = v[CW-1:0];
      end else if (v[SAT_W-1]) begin
         r = {1'b1, {(CW-1){1'b0}}};
      end else begin
         r = {1'b0, {(CW-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/tlq_geom.sv
// corner unit: normal, half width offset and the four unmapped corners
// a sequencer over shared shift, root and divide steps; uses tlq_pkg
`default_nettype none

module tlq_geom (
   input  logic               clock,
   input  logic               reset,
   input  logic               cfg_write,
   input  tlq_pkg::coord_type start_x,
   input  tlq_pkg::coord_type start_y,
   input  tlq_pkg::coord_type end_x,
   input  tlq_pkg::coord_type end_y,
   input  tlq_pkg::width_type line_width,
   output logic               busy,
   output tlq_pkg::quad_type  corners
);
   import tlq_pkg::*;

   localparam int NW = FRAC_BITS + 33;
   localparam int PW = QW + LW;
   localparam logic [PW-1:0] ROUND = PW'(1) << FRAC_BITS;

   geo_state_type state_ff, state_in;
   logic          run_ff, run_in;
   logic [32:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic          dx_neg_ff, dx_neg_in, dy_pos_ff, dy_pos_in;
   logic [63:0]   rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [32:0]   dvs_ff, dvs_in, remx_ff, remx_in, remy_ff, remy_in;
   logic [QW-1:0] numx_ff, numx_in, numy_ff, numy_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [31:0]   offx_ff, offx_in, offy_ff, offy_in;
   quad_type      corner_ff, corner_in;

   logic signed [32:0] dx, dy;
   logic [32:0]   mx;
   logic [61:0]   sqx, sqy;
   logic [63:0]   sum_rb;
   logic [NW-1:0] numx, numy;
   logic [33:0]   tx, ty;
   logic          gx, gy;
   logic [PW-1:0] prodx, prody;
   logic signed [33:0] ox, oy;

   always_comb begin
      dx     = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
      dy     = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
      mx     = (ax_ff > ay_ff) ? ax_ff : ay_ff;
      sqx    = ax_ff[30:0] * ax_ff[30:0];
      sqy    = ay_ff[30:0] * ay_ff[30:0];
      sum_rb = root_ff + bit_ff;
      numx   = NW'({ay_ff[30:0], {(FRAC_BITS+1){1'b0}}}) + NW'(root_ff[31:0]);
      numy   = NW'({ax_ff[30:0], {(FRAC_BITS+1){1'b0}}}) + NW'(root_ff[31:0]);
      tx     = {remx_ff, numx_ff[QW-1]};
      ty     = {remy_ff, numy_ff[QW-1]};
      gx     = tx >= {1'b0, dvs_ff};
      gy     = ty >= {1'b0, dvs_ff};
      prodx  = PW'(numx_ff) * PW'(line_width);
      prody  = PW'(numy_ff) * PW'(line_width);
      ox     = dy_pos_ff ? -$signed({2'b00, offx_ff}) : $signed({2'b00, offx_ff});
      oy     = dx_neg_ff ? -$signed({2'b00, offy_ff}) : $signed({2'b00, offy_ff});
   end

   always_comb begin
      state_in  = state_ff;
      run_in    = run_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      dx_neg_in = dx_neg_ff;
      dy_pos_in = dy_pos_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      dvs_in    = dvs_ff;
      remx_in   = remx_ff;
      remy_in   = remy_ff;
      numx_in   = numx_ff;
      numy_in   = numy_ff;
      cnt_in    = cnt_ff;
      offx_in   = offx_ff;
      offy_in   = offy_ff;
      corner_in = corner_ff;
      unique case (state_ff)
         GEO_START: begin
            ax_in     = dx[32] ? 33'(-dx) : 33'(dx);
            ay_in     = dy[32] ? 33'(-dy) : 33'(dy);
            dx_neg_in = dx[32];
            dy_pos_in = !dy[32] && (dy != '0);
            numx_in   = '0;
            numy_in   = '0;
            state_in  = (dx == '0 && dy == '0) ? GEO_SCALE : GEO_NORM;
         end
         GEO_NORM: begin
            // bring the larger magnitude into [2^30, 2^31)
            if (mx[32:31] != 2'b00) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end else if (!mx[30]) begin
               ax_in = ax_ff << 1;
               ay_in = ay_ff << 1;
            end else begin
               state_in = GEO_SQUARE;
            end
         end
         GEO_SQUARE: begin
            rad_in   = 64'(sqx) + 64'(sqy);
            root_in  = '0;
            bit_in   = 64'h4000_0000_0000_0000;
            state_in = GEO_ROOT;
         end
         GEO_ROOT: begin
            if (rad_ff >= sum_rb) begin
               rad_in  = rad_ff - sum_rb;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = GEO_PREP;
            end
         end
         GEO_PREP: begin
            dvs_in   = {root_ff[31:0], 1'b0};
            remx_in  = 33'(numx[NW-1:QW]);
            remy_in  = 33'(numy[NW-1:QW]);
            numx_in  = numx[QW-1:0];
            numy_in  = numy[QW-1:0];
            cnt_in   = 5'(QW - 1);
            state_in = GEO_DIVIDE;
         end
         GEO_DIVIDE: begin
            remx_in = gx ? 33'(tx - {1'b0, dvs_ff}) : tx[32:0];
            remy_in = gy ? 33'(ty - {1'b0, dvs_ff}) : ty[32:0];
            numx_in = {numx_ff[QW-2:0], gx};
            numy_in = {numy_ff[QW-2:0], gy};
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = GEO_SCALE;
            end
         end
         GEO_SCALE: begin
            offx_in  = 32'((prodx + ROUND) >> (FRAC_BITS + 1));
            offy_in  = 32'((prody + ROUND) >> (FRAC_BITS + 1));
            state_in = GEO_CORNER;
         end
         GEO_CORNER: begin
            if (run_ff) begin
               corner_in.x[0] = sat_coord(SAT_W'(start_x) + SAT_W'(ox));
               corner_in.y[0] = sat_coord(SAT_W'(start_y) + SAT_W'(oy));
               corner_in.x[1] = sat_coord(SAT_W'(end_x) + SAT_W'(ox));
               corner_in.y[1] = sat_coord(SAT_W'(end_y) + SAT_W'(oy));
               corner_in.x[2] = sat_coord(SAT_W'(end_x) - SAT_W'(ox));
               corner_in.y[2] = sat_coord(SAT_W'(end_y) - SAT_W'(oy));
               corner_in.x[3] = sat_coord(SAT_W'(start_x) - SAT_W'(ox));
               corner_in.y[3] = sat_coord(SAT_W'(start_y) - SAT_W'(oy));
            end
            run_in = 1'b0;
         end
         default: state_in = GEO_START;
      endcase
      // any register write restarts the whole computation
      if (cfg_write) begin
         state_in = GEO_START;
         run_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEO_START;
         run_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      dx_neg_ff <= dx_neg_in;
      dy_pos_ff <= dy_pos_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      dvs_ff    <= dvs_in;
      remx_ff   <= remx_in;
      remy_ff   <= remy_in;
      numx_ff   <= numx_in;
      numy_ff   <= numy_in;
      cnt_ff    <= cnt_in;
      offx_ff   <= offx_in;
      offy_ff   <= offy_in;
      corner_ff <= corner_in;
   end

   // idle once the corner step has run with no write pending
   assign busy    = run_ff;
   assign corners = corner_ff;

endmodule

`default_nettype wire

FILE: hdl/tlq_map.sv
// affine map of the four corners: product stage, then round and sum stage
// uses tlq_pkg
`default_nettype none

module tlq_map (
   input  logic               clock,
   input  logic               en_a,
   input  logic               en_b,
   input  tlq_pkg::quad_type  corners,
   input  tlq_pkg::coord_type mat_xx,
   input  tlq_pkg::coord_type mat_xy,
   input  tlq_pkg::coord_type mat_xt,
   input  tlq_pkg::coord_type mat_yx,
   input  tlq_pkg::coord_type mat_yy,
   input  tlq_pkg::coord_type mat_yt,
   output tlq_pkg::quad_type  mapped
);
   import tlq_pkg::*;

   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   logic signed [63:0] pxa_ff [4], pxb_ff [4], pya_ff [4], pyb_ff [4];
   coord_type          xt_ff, yt_ff;
   quad_type           mapped_ff, mapped_in;

   function automatic logic signed [SAT_W-1:0] rshift(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + HALF) >>> FRAC_BITS;
      return t[SAT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (en_a) begin
         for (int i = 0; i < 4; i++) begin
            pxa_ff[i] <= mat_xx * $signed(corners.x[i]);
            pxb_ff[i] <= mat_xy * $signed(corners.y[i]);
            pya_ff[i] <= mat_yx * $signed(corners.x[i]);
            pyb_ff[i] <= mat_yy * $signed(corners.y[i]);
         end
         xt_ff <= mat_xt;
         yt_ff <= mat_yt;
      end
   end

   always_comb begin
      mapped_in = mapped_ff;
      for (int i = 0; i < 4; i++) begin
         mapped_in.x[i] = sat_coord(rshift(pxa_ff[i]) + rshift(pxb_ff[i]) + SAT_W'(xt_ff));
         mapped_in.y[i] = sat_coord(rshift(pya_ff[i]) + rshift(pyb_ff[i]) + SAT_W'(yt_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         mapped_ff <= mapped_in;
      end
   end

   assign mapped = mapped_ff;

endmodule

`default_nettype wire

FILE: hdl/tlq_box.sv
// bounding box of the mapped corners: pairwise stage, then final stage
// uses tlq_pkg
`default_nettype none

module tlq_box (
   input  logic               clock,
   input  logic               en_c,
   input  logic               en_d,
   input  tlq_pkg::quad_type  mapped,
   output tlq_pkg::quad_type  quad,
   output tlq_pkg::coord_type box_x,
   output tlq_pkg::coord_type box_y,
   output tlq_pkg::width_type box_w,
   output tlq_pkg::width_type box_h
);
   import tlq_pkg::*;

   quad_type  quad_c_ff, quad_d_ff;
   coord_type mnx_ff [2], mxx_ff [2], mny_ff [2], mxy_ff [2];
   coord_type minx_ff, miny_ff, minx, maxx, miny, maxy;
   width_type w_ff, h_ff;
   logic signed [32:0] w, h;

   always_ff @(posedge clock) begin
      if (en_c) begin
         quad_c_ff <= mapped;
         for (int k = 0; k < 2; k++) begin
            mnx_ff[k] <= ($signed(mapped.x[2*k+1]) < $signed(mapped.x[2*k]))
                         ? mapped.x[2*k+1] : mapped.x[2*k];
            mxx_ff[k] <= ($signed(mapped.x[2*k+1]) > $signed(mapped.x[2*k]))
                         ? mapped.x[2*k+1] : mapped.x[2*k];
            mny_ff[k] <= ($signed(mapped.y[2*k+1]) < $signed(mapped.y[2*k]))
                         ? mapped.y[2*k+1] : mapped.y[2*k];
            mxy_ff[k] <= ($signed(mapped.y[2*k+1]) > $signed(mapped.y[2*k]))
                         ? mapped.y[2*k+1] : mapped.y[2*k];
         end
      end
   end

   always_comb begin
      minx = (mnx_ff[1] < mnx_ff[0]) ? mnx_ff[1] : mnx_ff[0];
      maxx = (mxx_ff[1] > mxx_ff[0]) ? mxx_ff[1] : mxx_ff[0];
      miny = (mny_ff[1] < mny_ff[0]) ? mny_ff[1] : mny_ff[0];
      maxy = (mxy_ff[1] > mxy_ff[0]) ? mxy_ff[1] : mxy_ff[0];
      w    = 33'(maxx) - 33'(minx);
      h    = 33'(maxy) - 33'(miny);
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         quad_d_ff <= quad_c_ff;
         minx_ff   <= minx;
         miny_ff   <= miny;
         w_ff      <= (w[32:31] != 2'b00) ? '1 : w[30:0];
         h_ff      <= (h[32:31] != 2'b00) ? '1 : h[30:0];
      end
   end

   assign quad  = quad_d_ff;
   assign box_x = minx_ff;
   assign box_y = miny_ff;
   assign box_w = w_ff;
   assign box_h = h_ff;

endmodule

`default_nettype wire

FILE: hdl/thick_line_quad_transform_aabb_unit.sv
// Maps a thick line segment held in registers through one 2x3 affine matrix per beat and
// returns the four mapped corners with their bounding box. One beat is taken every cycle
// while req_stall is low; each result passes the registered stages product, round and sum,
// pairwise min/max and final box. After reset and after every register write the corner unit
// recomputes the normal and corners (normalize shifts, 32 root steps, 18 divide steps, and
// the start, square, prep, scale and corner steps); req_stall is high meanwhile.
// uses tlq_pkg, tlq_geom, tlq_map, tlq_box and the macros header
`default_nettype none
`include "thick_line_quad_transform_aabb_unit_macros.svh"

module thick_line_quad_transform_aabb_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   input  logic               req_valid,
   output logic               req_stall,
   input  tlq_pkg::coord_type req_mat_xx,
   input  tlq_pkg::coord_type req_mat_xy,
   input  tlq_pkg::coord_type req_mat_xt,
   input  tlq_pkg::coord_type req_mat_yx,
   input  tlq_pkg::coord_type req_mat_yy,
   input  tlq_pkg::coord_type req_mat_yt,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlq_pkg::coord_type rsp_c0_x,
   output tlq_pkg::coord_type rsp_c0_y,
   output tlq_pkg::coord_type rsp_c1_x,
   output tlq_pkg::coord_type rsp_c1_y,
   output tlq_pkg::coord_type rsp_c2_x,
   output tlq_pkg::coord_type rsp_c2_y,
   output tlq_pkg::coord_type rsp_c3_x,
   output tlq_pkg::coord_type rsp_c3_y,
   output tlq_pkg::coord_type rsp_box_x,
   output tlq_pkg::coord_type rsp_box_y,
   output tlq_pkg::width_type rsp_box_w,
   output tlq_pkg::width_type rsp_box_h
);
   import tlq_pkg::*;

   coord_type start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   width_type line_width_ff;
   logic      cfg_write, busy;
   logic [2:0] reg_idx;
   quad_type  corners, mapped, quad;
   logic      va_ff, vb_ff, vc_ff, vd_ff;
   logic      rdy_a, rdy_b, rdy_c, rdy_d;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[4:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         end_x_ff      <= '0;
         end_y_ff      <= '0;
         line_width_ff <= '0;
      end else if (cfg_write) begin
         unique case (reg_idx)
            REG_START_X:    start_x_ff    <= pwdata;
            REG_START_Y:    start_y_ff    <= pwdata;
            REG_END_X:      end_x_ff      <= pwdata;
            REG_END_Y:      end_y_ff      <= pwdata;
            REG_LINE_WIDTH: line_width_ff <= pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_START_X:    prdata = start_x_ff;
         REG_START_Y:    prdata = start_y_ff;
         REG_END_X:      prdata = end_x_ff;
         REG_END_Y:      prdata = end_y_ff;
         REG_LINE_WIDTH: prdata = {1'b0, line_width_ff};
         default:        prdata = '0;
      endcase
   end

   // each stage loads when it is empty or its successor moves on
   assign rdy_d     = !vd_ff || !rsp_stall;
   assign rdy_c     = !vc_ff || rdy_d;
   assign rdy_b     = !vb_ff || rdy_c;
   assign rdy_a     = !va_ff || rdy_b;
   assign req_stall = busy || !rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_valid && !busy;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
      end
   end

   tlq_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .cfg_write  (cfg_write),
      .start_x    (start_x_ff),
      .start_y    (start_y_ff),
      .end_x      (end_x_ff),
      .end_y      (end_y_ff),
      .line_width (line_width_ff),
      .busy       (busy),
      .corners    (corners)
   );

   tlq_map u_map (
      .clock   (clock),
      .en_a    (rdy_a),
      .en_b    (rdy_b),
      .corners (corners),
      .mat_xx  (req_mat_xx),
      .mat_xy  (req_mat_xy),
      .mat_xt  (req_mat_xt),
      .mat_yx  (req_mat_yx),
      .mat_yy  (req_mat_yy),
      .mat_yt  (req_mat_yt),
      .mapped  (mapped)
   );

   tlq_box u_box (
      .clock  (clock),
      .en_c   (rdy_c),
      .en_d   (rdy_d),
      .mapped (mapped),
      .quad   (quad),
      .box_x  (rsp_box_x),
      .box_y  (rsp_box_y),
      .box_w  (rsp_box_w),
      .box_h  (rsp_box_h)
   );

   assign rsp_valid = vd_ff;
   assign rsp_c0_x  = quad.x[0];
   assign rsp_c0_y  = quad.y[0];
   assign rsp_c1_x  = quad.x[1];
   assign rsp_c1_y  = quad.y[1];
   assign rsp_c2_x  = quad.x[2];
   assign rsp_c2_y  = quad.y[2];
   assign rsp_c3_x  = quad.x[3];
   assign rsp_c3_y  = quad.y[3];

   `TLQ_ASSERT_NOW(a_busy_stalls, busy, req_stall, "request taken while corners recompute")
   `TLQ_ASSERT_NEXT(a_write_busy, cfg_write, busy, "register write did not start corner unit")
   `TLQ_ASSERT_NOW(a_box_min, rsp_valid, rsp_box_x <= rsp_c0_x, "box x above a corner")

endmodule

`default_nettype wire

FILE: test/tb_thick_line_quad_transform_aabb_unit.sv
// testbench for thick_line_quad_transform_aabb_unit: register settings, matrix beats, random idling
// predicts each mapped quad and bounding box and checks every result beat; depends on tlq_pkg
`timescale 1ns / 100ps

module tb_thick_line_quad_transform_aabb_unit;
   import tlq_pkg::*;

   typedef logic [11:0][31:0] quad_box_type;
   typedef logic [5:0][31:0]  matrix_type;

   class quad_scoreboard;
      longint       seg_sx, seg_sy, seg_ex, seg_ey, thickness;
      quad_box_type pending_boxes[$];
      int           mismatches;
      string        field_names[12] = '{"c0_x", "c0_y", "c1_x", "c1_y", "c2_x", "c2_y",
                                        "c3_x", "c3_y", "box_x", "box_y", "box_w", "box_h"};

      function void set_register(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_START_X: seg_sx = longint'($signed(value));
            REG_START_Y: seg_sy = longint'($signed(value));
            REG_END_X: seg_ex = longint'($signed(value));
            REG_END_Y: seg_ey = longint'($signed(value));
            REG_LINE_WIDTH: thickness = longint'(value[30:0]);
            default: ;
         endcase
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // product rounded half up to the fraction width, i.e. floor((p + half) / one)
      function longint mul_round(longint a, longint b);
         return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      endfunction

      function void note_matrix(matrix_type mat);
         longint m[6], dx, dy, ox, oy, cx[4], cy[4], px[4], py[4];
         longint mnx, mxx, mny, mxy, w, h;
         longint unsigned ax, ay, big, len, nxm, nym, oxm, oym;
         quad_box_type r;
         for (int i = 0; i < 6; i++) m[i] = longint'($signed(mat[i]));
         dx = seg_ex - seg_sx;
         dy = seg_ey - seg_sy;
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         nxm = 0;
         nym = 0;
         if (ax != 0 || ay != 0) begin
            big = ax > ay ? ax : ay;
            while (big >= (64'd1 << 31)) begin
               ax = ax >> 1; ay = ay >> 1; big = big >> 1;
            end
            while (big < (64'd1 << 30)) begin
               ax = ax << 1; ay = ay << 1; big = big << 1;
            end
            len = floor_root(ax * ax + ay * ay);
            nxm = ((ay << (FRAC_BITS + 1)) + len) / (2 * len);
            nym = ((ax << (FRAC_BITS + 1)) + len) / (2 * len);
         end
         oxm = (nxm * longint'(thickness) + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
         oym = (nym * longint'(thickness) + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
         ox = dy > 0 ? -longint'(oxm) : longint'(oxm);
         oy = dx < 0 ? -longint'(oym) : longint'(oym);
         cx[0] = clamp32(seg_sx + ox); cy[0] = clamp32(seg_sy + oy);
         cx[1] = clamp32(seg_ex + ox); cy[1] = clamp32(seg_ey + oy);
         cx[2] = clamp32(seg_ex - ox); cy[2] = clamp32(seg_ey - oy);
         cx[3] = clamp32(seg_sx - ox); cy[3] = clamp32(seg_sy - oy);
         for (int i = 0; i < 4; i++) begin
            px[i] = clamp32(mul_round(m[0], cx[i]) + mul_round(m[1], cy[i]) + m[2]);
            py[i] = clamp32(mul_round(m[3], cx[i]) + mul_round(m[4], cy[i]) + m[5]);
         end
         mnx = px[0]; mxx = px[0]; mny = py[0]; mxy = py[0];
         for (int i = 1; i < 4; i++) begin
            if (px[i] < mnx) mnx = px[i];
            if (px[i] > mxx) mxx = px[i];
            if (py[i] < mny) mny = py[i];
            if (py[i] > mxy) mxy = py[i];
         end
         w = clamp32(mxx - mnx);
         h = clamp32(mxy - mny);
         for (int i = 0; i < 4; i++) begin
            r[2 * i] = px[i][31:0];
            r[2 * i + 1] = py[i][31:0];
         end
         r[8] = mnx[31:0];
         r[9] = mny[31:0];
         r[10] = {1'b0, w[30:0]};
         r[11] = {1'b0, h[30:0]};
         pending_boxes.insert(pending_boxes.size(), r);
      endfunction

      function void check_result(quad_box_type got);
         quad_box_type want;
         if (pending_boxes.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            mismatches++;
            return;
         end
         want = pending_boxes.pop_front();
         for (int i = 0; i < 12; i++) begin
            if (want[i] !== got[i]) begin
               $display("%0t: %s expected %h actual %h", $time, field_names[i], want[i], got[i]);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic               clock, reset;
   logic               psel, penable, pwrite, pready;
   logic [4:0]         paddr;
   logic [31:0]        pwdata, prdata;
   logic               req_valid, req_stall, rsp_valid, rsp_stall;
   coord_type          req_mat_xx, req_mat_xy, req_mat_xt, req_mat_yx, req_mat_yy, req_mat_yt;
   coord_type          rsp_c0_x, rsp_c0_y, rsp_c1_x, rsp_c1_y, rsp_c2_x, rsp_c2_y;
   coord_type          rsp_c3_x, rsp_c3_y, rsp_box_x, rsp_box_y;
   width_type          rsp_box_w, rsp_box_h;

   quad_scoreboard     board = new();
   int                 idle_cycles;
   int                 stall_mode;
   int                 stall_left;

   localparam int IDLE_LIMIT = 3000;
   localparam int ONE = 1 << FRAC_BITS;

   thick_line_quad_transform_aabb_unit DUT (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mat_xx(req_mat_xx), .req_mat_xy(req_mat_xy), .req_mat_xt(req_mat_xt),
      .req_mat_yx(req_mat_yx), .req_mat_yy(req_mat_yy), .req_mat_yt(req_mat_yt),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_c0_x(rsp_c0_x), .rsp_c0_y(rsp_c0_y), .rsp_c1_x(rsp_c1_x), .rsp_c1_y(rsp_c1_y),
      .rsp_c2_x(rsp_c2_x), .rsp_c2_y(rsp_c2_y), .rsp_c3_x(rsp_c3_x), .rsp_c3_y(rsp_c3_y),
      .rsp_box_x(rsp_box_x), .rsp_box_y(rsp_box_y), .rsp_box_w(rsp_box_w), .rsp_box_h(rsp_box_h)
   );

   // starts low so the first rising edge comes after the initial values settle
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // both channels sampled at the edge; watchdog counts edges with no beat at all
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_matrix({req_mat_yt, req_mat_yy, req_mat_yx,
                               req_mat_xt, req_mat_xy, req_mat_xx});
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_result({1'b0, rsp_box_h, 1'b0, rsp_box_w, rsp_box_y, rsp_box_x,
                                rsp_c3_y, rsp_c3_x, rsp_c2_y, rsp_c2_x,
                                rsp_c1_y, rsp_c1_x, rsp_c0_y, rsp_c0_x});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("thick_line_quad_transform_aabb_unit verification failed");
            $finish;
         end
      end
   end

   // receiver stall: switches among never, random and long stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(10, 80);
         rsp_stall <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ($urandom_range(0, 7) != 0);
            3: rsp_stall <= ($urandom_range(0, 5) == 0);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      board.set_register(index, value);
   endtask

   task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                              logic [31:0] ey, logic [31:0] lw);
      write_register(REG_START_X, sx);
      write_register(REG_START_Y, sy);
      write_register(REG_END_X, ex);
      write_register(REG_END_Y, ey);
      write_register(REG_LINE_WIDTH, lw);
   endtask

   // hold valid low until the pipeline has drained
   task automatic drain();
      @(posedge clock);
      req_valid <= 1'b0;
      while (board.pending_boxes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one beat, driven right at the current edge; valid stays up when the burst goes on
   task automatic send_matrix(matrix_type mat, bit keep_valid);
      req_valid <= 1'b1;
      {req_mat_yt, req_mat_yy, req_mat_yx, req_mat_xt, req_mat_xy, req_mat_xx} <= mat;
      do @(posedge clock); while (req_stall);
      if (!keep_valid) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $signed($urandom_range(0, 400 * ONE)) - 200 * ONE;
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < 6; i++) m[i] = $urandom();
      end else begin
         for (int i = 0; i < 6; i++) m[i] = $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
         if ($urandom_range(0, 5) == 0) m[$urandom_range(0, 5)] = random_coord();
      end
      return m;
   endfunction

   task automatic send_burst(int count);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         if (burst > left) burst = left;
         for (int i = 0; i < burst; i++) send_matrix(random_matrix(), i != burst - 1);
         left -= burst;
      end
   endtask

   matrix_type directed[$];

   initial begin
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_valid = 1'b0; rsp_stall = 1'b0;
      req_mat_xx = '0; req_mat_xy = '0; req_mat_xt = '0;
      req_mat_yx = '0; req_mat_yy = '0; req_mat_yt = '0;
      idle_cycles = 0; stall_mode = 0; stall_left = 0;
      board.mismatches = 0;
      board.set_register(REG_START_X, 0);
      board.set_register(REG_START_Y, 0);
      board.set_register(REG_END_X, 0);
      board.set_register(REG_END_Y, 0);
      board.set_register(REG_LINE_WIDTH, 0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset registers: zero-length segment, zero width
      send_matrix({32'd0, 32'(ONE), 32'd0, 32'd0, 32'd0, 32'(ONE)}, 0);
      drain();

      set_segment(32'd0, 32'd0, 32'(10 * ONE), 32'(3 * ONE), 32'(2 * ONE));
      directed.insert(directed.size(), {32'd0, 32'(ONE), 32'd0, 32'd0, 32'd0, 32'(ONE)});
      directed.insert(directed.size(), {32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
      directed.insert(directed.size(),
                      {32'(5 * ONE), 32'd0, 32'(ONE), 32'(7 * ONE), 32'(-ONE), 32'd0});
      directed.insert(directed.size(), {6{32'h7fff_ffff}});
      directed.insert(directed.size(), {6{32'h8000_0000}});
      directed.insert(directed.size(), {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
      directed.insert(directed.size(), {6{32'hffff_ffff}});
      directed.insert(directed.size(), {32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1});
      foreach (directed[i]) send_matrix(directed[i], i != directed.size() - 1);
      drain();

      // widest segment and widest line
      set_segment(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      foreach (directed[i]) send_matrix(directed[i], 1);
      send_matrix(random_matrix(), 0);
      drain();

      // zero-length segment with full width, then a vertical line from a higher to a lower y
      set_segment(32'(3 * ONE), 32'(-4 * ONE), 32'(3 * ONE), 32'(-4 * ONE), 32'h7fff_ffff);
      send_matrix(directed[0], 1);
      send_matrix(directed[3], 0);
      drain();
      set_segment(32'd0, 32'(9 * ONE), 32'd0, 32'(-ONE), 32'(ONE + 1));
      send_matrix(directed[0], 1);
      send_matrix(directed[2], 0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         set_segment(random_coord(), random_coord(), random_coord(), random_coord(),
                     ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 16 * ONE));
         send_burst(45);
         drain();
         send_burst(48);
         drain();
      end

      while (board.pending_boxes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("thick_line_quad_transform_aabb_unit verification clean");
      end else begin
         $display("thick_line_quad_transform_aabb_unit verification failed");
      end
      $finish;
   end

endmodule
